### hw/rtl/idct_pkg.sv
// ----------------------------------------------------------------------------
// idct_pkg
// Shared constants of the 8x8 islow inverse DCT: widths, level shifts and the
// 1-D kernel folded into one integer matrix (13-bit fixed point).
// ----------------------------------------------------------------------------
`default_nettype none
package idct_pkg;

    localparam int SAMPLE_W = 12;
    localparam int CONST_W  = 16;

    localparam int LEVEL_8  = 128;
    localparam int LEVEL_12 = 2048;
    localparam int MAXV_8   = 255;
    localparam int MAXV_12  = 4095;

    localparam int SAT_HI   = 32767;
    localparam int SAT_LO   = -32768;

    // Kernel output k as a weighted sum of inputs j, entry index k*8+j.
    // Even part and odd part of the islow butterfly multiplied out.
    localparam logic signed [CONST_W-1:0] KMAT [64] = '{
        16'sd8192,  16'sd11363,  16'sd10703,  16'sd9633,
        16'sd8192,  16'sd6437,   16'sd4433,   16'sd2260,
        16'sd8192,  16'sd9633,   16'sd4433,  -16'sd2259,
       -16'sd8192, -16'sd11362, -16'sd10704, -16'sd6436,
        16'sd8192,  16'sd6437,  -16'sd4433,  -16'sd11362,
       -16'sd8192,  16'sd2261,   16'sd10704,  16'sd9633,
        16'sd8192,  16'sd2260,  -16'sd10703, -16'sd6436,
        16'sd8192,  16'sd9633,  -16'sd4433,  -16'sd11363,
        16'sd8192, -16'sd2260,  -16'sd10703,  16'sd6436,
        16'sd8192, -16'sd9633,  -16'sd4433,   16'sd11363,
        16'sd8192, -16'sd6437,  -16'sd4433,   16'sd11362,
       -16'sd8192, -16'sd2261,   16'sd10704, -16'sd9633,
        16'sd8192, -16'sd9633,   16'sd4433,   16'sd2259,
       -16'sd8192,  16'sd11362, -16'sd10704,  16'sd6436,
        16'sd8192, -16'sd11363,  16'sd10703, -16'sd9633,
        16'sd8192, -16'sd6437,   16'sd4433,  -16'sd2260
    };

endpackage
`default_nettype wire

### hw/rtl/idct_if.sv
// ----------------------------------------------------------------------------
// idct channel interfaces
// Valid/ready channels for coefficients in, samples out and the mode write.
// ----------------------------------------------------------------------------
`default_nettype none
interface idct_coef_if #(parameter int COEFF_BITS = 21);
    logic                         valid;
    logic                         ready;
    logic signed [COEFF_BITS-1:0] coefficient;
    modport source (output valid, output coefficient, input ready);
    modport sink   (input valid, input coefficient, output ready);
endinterface

interface idct_samp_if;
    import idct_pkg::*;
    logic                valid;
    logic                ready;
    logic [SAMPLE_W-1:0] sample;
    logic                last_of_block;
    modport source (output valid, output sample, output last_of_block, input ready);
    modport sink   (input valid, input sample, input last_of_block, output ready);
endinterface

interface idct_cfg_if;
    logic valid;
    logic ready;
    logic twelve_bit_mode;
    modport source (output valid, output twelve_bit_mode, input ready);
    modport sink   (input valid, input twelve_bit_mode, output ready);
endinterface
`default_nettype wire

### hw/rtl/idct_8x8_islow.sv
// ----------------------------------------------------------------------------
// idct_8x8_islow
// 8x8 islow inverse DCT: loads 64 coefficients, runs 8 column and 8 row
// transforms through an 8-lane multiply-accumulate over two block memories.
// ----------------------------------------------------------------------------
// Load: 64 items, one per cycle while the input is valid. Compute: 16
// transforms, each reading 8 inputs through the single read port of the
// coefficient/workspace memories, letting the pipeline empty, then draining
// 8 outputs. Samples leave one per cycle from the row drain while the
// receiver is ready; the next block may load while the last sample waits.
// Sync active-low reset clears control only; memories hold no reset value.
`default_nettype none
module idct_8x8_islow #(
    parameter int COEFF_BITS = 21
) (
    input  wire        i_clk,
    input  wire        i_rst_n,
    idct_coef_if.sink  i_coef,
    idct_samp_if.source o_samp,
    idct_cfg_if.sink   i_cfg
);
    import idct_pkg::*;

    localparam int WS_W  = (COEFF_BITS + 4 > 32) ? COEFF_BITS + 4 : 32;
    localparam int ACC_W = COEFF_BITS + 21;
    localparam int PRD_W = WS_W + CONST_W;

    localparam logic [1:0] S_LOAD  = 2'd0;
    localparam logic [1:0] S_READ  = 2'd1;
    localparam logic [1:0] S_WAIT  = 2'd2;
    localparam logic [1:0] S_DRAIN = 2'd3;

    typedef logic signed [ACC_W-1:0] t_acc;

    // wrap to int32 in 8-bit mode
    function automatic t_acc f_fit(input t_acc x, input logic w32);
        return w32 ? ACC_W'(signed'(x[31:0])) : x;
    endfunction

    // rounding right shift
    function automatic t_acc f_desc(input t_acc x, input logic [4:0] n, input logic w32);
        t_acc y;
        y = f_fit(f_fit(x, w32) + (t_acc'(1) <<< (n - 5'd1)), w32);
        return y >>> n;
    endfunction

    // level shift and clamp
    function automatic logic [SAMPLE_W-1:0] f_finish(input t_acc y, input logic w32);
        t_acc z;
        t_acc mx;
        z  = f_fit(y + (w32 ? t_acc'(LEVEL_8) : t_acc'(LEVEL_12)), w32);
        mx = w32 ? t_acc'(MAXV_8) : t_acc'(MAXV_12);
        if (z < 0) return '0;
        if (z > mx) return SAMPLE_W'(mx);
        return SAMPLE_W'(z);
    endfunction

    // control registers
    logic [1:0] r_state;
    logic       r_pass;
    logic [2:0] r_i, r_j, r_k;
    logic [5:0] r_load;
    logic       r_mode, r_bmode;
    logic       r_v1, r_v2;
    logic [2:0] r_j1, r_j2;
    logic       r_acnz;
    logic       r_ov;

    // payload registers
    logic signed [COEFF_BITS-1:0] r_crd;
    logic signed [WS_W-1:0]       r_wrd;
    logic signed [WS_W-1:0]       r_v0;
    t_acc                         r_prod [8];
    t_acc                         r_acc  [8];
    logic [SAMPLE_W-1:0]          r_os;
    logic                         r_olast;

    // memories
    logic signed [COEFF_BITS-1:0] cmem [64];
    logic signed [WS_W-1:0]       wmem [64];

    logic                  w32;
    logic                  coef_acc;
    logic                  out_free;
    logic                  drain_step;
    logic signed [WS_W-1:0] v1;
    logic signed [PRD_W-1:0] prod_full [8];
    t_acc                  sel, v0x;
    logic [1:0]            p1;
    logic signed [WS_W-1:0] ws_wdata;
    logic [SAMPLE_W-1:0]   samp;

    assign w32        = !r_bmode;
    assign p1         = w32 ? 2'd2 : 2'd1;
    assign i_coef.ready = (r_state == S_LOAD);
    assign coef_acc   = i_coef.valid && i_coef.ready;
    assign i_cfg.ready = 1'b1;
    assign out_free   = !r_ov || o_samp.ready;
    assign drain_step = (r_state == S_DRAIN) && (!r_pass || out_free);

    assign o_samp.valid         = r_ov;
    assign o_samp.sample        = r_os;
    assign o_samp.last_of_block = r_olast;

    // mode register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= 1'b0;
        end else if (i_cfg.valid) begin
            r_mode <= i_cfg.twelve_bit_mode;
        end
    end

    // coefficient store, write on load, read column-wise
    always_ff @(posedge i_clk) begin
        if (coef_acc) begin
            cmem[r_load] <= i_coef.coefficient[COEFF_BITS-1:0];
        end
        r_crd <= cmem[{r_j, r_i}];
    end

    // workspace, written by column drain, read row-wise
    always_ff @(posedge i_clk) begin
        if (drain_step && !r_pass) begin
            wmem[{r_k, r_i}] <= ws_wdata;
        end
        r_wrd <= wmem[{r_i, r_j}];
    end

    // stage 1 operand: saturate coefficients in 8-bit mode
    always_comb begin
        if (!r_pass) begin
            v1 = WS_W'(r_crd);
            if (w32 && v1 > WS_W'(SAT_HI)) v1 = WS_W'(SAT_HI);
            if (w32 && v1 < WS_W'(SAT_LO)) v1 = WS_W'(SAT_LO);
        end else begin
            v1 = r_wrd;
        end
        for (int k = 0; k < 8; k++) begin
            prod_full[k] = PRD_W'(v1) * PRD_W'(KMAT[{3'(k), r_j1}]);
        end
    end

    // lane products and accumulators
    always_ff @(posedge i_clk) begin
        if (r_v1) begin
            for (int k = 0; k < 8; k++) r_prod[k] <= ACC_W'(prod_full[k]);
            if (r_j1 == 3'd0) r_v0 <= v1;
        end
        if (r_v2) begin
            for (int k = 0; k < 8; k++) begin
                r_acc[k] <= (r_j2 == 3'd0) ? r_prod[k] : r_acc[k] + r_prod[k];
            end
        end
    end

    // drain value: full path or DC-only shortcut
    always_comb begin
        sel = r_acc[r_k];
        v0x = ACC_W'(r_v0);
        if (r_acnz) begin
            ws_wdata = WS_W'(f_desc(sel, 5'(13 - p1), w32));
            samp     = f_finish(f_desc(sel, 5'(16 + p1), w32), w32);
        end else begin
            ws_wdata = WS_W'(f_fit(v0x <<< p1, w32));
            samp     = f_finish(f_desc(v0x, 5'(3 + p1), w32), w32);
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (drain_step && r_pass) begin
            r_ov <= 1'b1;
        end else if (o_samp.ready) begin
            r_ov <= 1'b0;
        end
        if (drain_step && r_pass) begin
            r_os    <= samp;
            r_olast <= (r_i == 3'd7) && (r_k == 3'd7);
        end
    end

    // sequencer and pipeline control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
            r_pass  <= 1'b0;
            r_i     <= '0;
            r_j     <= '0;
            r_k     <= '0;
            r_load  <= '0;
            r_bmode <= 1'b0;
            r_v1    <= 1'b0;
            r_v2    <= 1'b0;
            r_j1    <= '0;
            r_j2    <= '0;
            r_acnz  <= 1'b0;
        end else begin
            r_v1 <= (r_state == S_READ);
            r_j1 <= r_j;
            r_v2 <= r_v1;
            r_j2 <= r_j1;
            if (r_v1) begin
                if (r_j1 == 3'd0) r_acnz <= 1'b0;
                else if (v1 != '0) r_acnz <= 1'b1;
            end
            case (r_state)
                S_LOAD: begin
                    if (coef_acc) begin
                        r_load <= r_load + 6'd1;
                        if (r_load == 6'd63) begin
                            r_bmode <= r_mode;
                            r_pass  <= 1'b0;
                            r_i     <= '0;
                            r_j     <= '0;
                            r_state <= S_READ;
                        end
                    end
                end
                S_READ: begin
                    r_j <= r_j + 3'd1;
                    if (r_j == 3'd7) r_state <= S_WAIT;
                end
                S_WAIT: begin
                    if (!r_v1 && !r_v2) begin
                        r_k     <= '0;
                        r_state <= S_DRAIN;
                    end
                end
                S_DRAIN: begin
                    if (drain_step) begin
                        r_k <= r_k + 3'd1;
                        if (r_k == 3'd7) begin
                            r_i <= r_i + 3'd1;
                            if (r_i != 3'd7) begin
                                r_state <= S_READ;
                            end else if (!r_pass) begin
                                r_pass  <= 1'b1;
                                r_state <= S_READ;
                            end else begin
                                r_state <= S_LOAD;
                            end
                        end
                    end
                end
                default: r_state <= S_LOAD;
            endcase
        end
    end

    // checks
    a_drain_flushed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DRAIN) |-> (!r_v1 && !r_v2))
        else $error("drain with accumulation in flight");
    a_block_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (coef_acc && r_load == 6'd63) |=> (r_state == S_READ && !r_pass && r_i == 3'd0))
        else $error("64th item did not start the column pass");
    a_wait_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WAIT) |-> (r_j == 3'd0))
        else $error("read index not wrapped");
    a_last_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (drain_step && r_pass && r_i == 3'd7 && r_k == 3'd7) |=>
        (r_ov && r_olast && r_state == S_LOAD))
        else $error("last sample not marked at block end");

endmodule
`default_nettype wire

### test/tb_idct_8x8_islow.sv
// ----------------------------------------------------------------------------
// tb_idct_8x8_islow
// Self-checking bench for the 8x8 islow inverse DCT. Coefficient blocks are
// streamed in through the valid/ready channel. A bit-exact predictor in the
// bench computes the 64 samples of each block. The samples that come out are
// checked in order. Both precision modes are exercised, with random
// back-pressure and idling, and one long output stall.
// ----------------------------------------------------------------------------
module tb_idct_8x8_islow;
    timeunit 1ns;
    timeprecision 1ps;
    import idct_pkg::*;

    localparam int CB       = 21;
    localparam int LIMIT    = 200000;
    localparam int SETTLE   = 400;

    typedef struct packed {
        logic [SAMPLE_W-1:0] sample;
        logic                last;
    } t_samp;

    typedef enum int {BLK_SPARSE, BLK_FULL, BLK_DC_ROW, BLK_INT16} t_blk_kind;

    logic i_clk;
    logic i_rst_n;

    idct_coef_if #(.COEFF_BITS(CB)) coef ();
    idct_samp_if                    samp ();
    idct_cfg_if                     cfg ();

    idct_8x8_islow #(.COEFF_BITS(CB)) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_coef  (coef.sink),
        .o_samp  (samp.source),
        .i_cfg   (cfg.sink)
    );

    // bench state
    logic signed [CB-1:0] coef_pending [$];
    t_samp                expected_samples [$];
    logic signed [CB-1:0] coef_store [64];
    int                   load_idx;
    bit                   mode12;
    bit                   coef_taken;
    int                   send_idle;
    int                   recv_idle;
    int                   hold_cycles;
    int                   errors;
    int                   cycles;
    int                   blocks_done;
    int                   samples_checked;
    int                   out_idx;

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // timeout
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("tb_idct_8x8_islow: errors");
            $finish;
        end
    end

    task automatic report_mismatch(input string what, input int idx,
                                   input longint got, input longint want);
        $display("mismatch %s at sample %0d: got %0d, expected %0d", what, idx, got, want);
        errors++;
    endtask

    // ---------------- predictor ----------------
    function automatic logic [63:0] wrap(input logic [63:0] x, input bit w32);
        return w32 ? {{32{x[31]}}, x[31:0]} : x;
    endfunction

    function automatic logic [63:0] round_shift(input logic [63:0] x, input int n,
                                                input bit w32);
        logic [63:0] y;
        y = wrap(x + (64'd1 << (n - 1)), w32);
        y = $signed(y) >>> n;
        return wrap(y, w32);
    endfunction

    function automatic logic [63:0] level_clamp(input logic [63:0] x, input logic [63:0] lvl,
                                                input logic [63:0] mx, input bit w32);
        logic [63:0] y;
        y = wrap(x + lvl, w32);
        if (y[63]) return 64'd0;
        return (y > mx) ? mx : y;
    endfunction

    // one 1-D islow butterfly, all arithmetic modulo 2^64
    function automatic void idct_1d(input logic [63:0] v[8], output logic [63:0] r[8]);
        logic [63:0] z1, z2, z3, z4, z5, t0, t1, t2, t3, t10, t11, t12, t13;
        logic [63:0] a0, a1, a2, a3;
        z1 = (v[2] + v[6]) * 64'd4433;
        t2 = z1 + v[6] * (64'd0 - 64'd15137);
        t3 = z1 + v[2] * 64'd6270;
        t0 = (v[0] + v[4]) << 13;
        t1 = (v[0] - v[4]) << 13;
        t10 = t0 + t3; t13 = t0 - t3; t11 = t1 + t2; t12 = t1 - t2;
        a0 = v[7]; a1 = v[5]; a2 = v[3]; a3 = v[1];
        z1 = a0 + a3; z2 = a1 + a2; z3 = a0 + a2; z4 = a1 + a3;
        z5 = (z3 + z4) * 64'd9633;
        a0 = a0 * 64'd2446; a1 = a1 * 64'd16819;
        a2 = a2 * 64'd25172; a3 = a3 * 64'd12299;
        z1 = z1 * (64'd0 - 64'd7373);
        z2 = z2 * (64'd0 - 64'd20995);
        z3 = z3 * (64'd0 - 64'd16069);
        z4 = z4 * (64'd0 - 64'd3196);
        z3 = z3 + z5; z4 = z4 + z5;
        a0 = a0 + z1 + z3; a1 = a1 + z2 + z4;
        a2 = a2 + z2 + z3; a3 = a3 + z1 + z4;
        r[0] = t10 + a3; r[7] = t10 - a3;
        r[1] = t11 + a2; r[6] = t11 - a2;
        r[2] = t12 + a1; r[5] = t12 - a1;
        r[3] = t13 + a0; r[4] = t13 - a0;
    endfunction

    // full block: column pass into workspace, row pass into samples
    function automatic void predict_block();
        logic [63:0] c[64];
        logic [63:0] ws[64];
        logic [63:0] v[8];
        logic [63:0] r[8];
        logic [63:0] lvl, mx, d;
        t_samp       s;
        bit          w32, dc;
        int          p1;
        w32 = !mode12;
        p1  = w32 ? 2 : 1;
        lvl = w32 ? 64'(LEVEL_8) : 64'(LEVEL_12);
        mx  = w32 ? 64'(MAXV_8) : 64'(MAXV_12);
        for (int i = 0; i < 64; i++) begin
            c[i] = {{(64-CB){coef_store[i][CB-1]}}, coef_store[i]};
            if (w32) begin
                if ($signed(c[i]) < SAT_LO) c[i] = 64'(SAT_LO);
                else if ($signed(c[i]) > SAT_HI) c[i] = 64'(SAT_HI);
            end
        end
        for (int i = 0; i < 8; i++) begin
            dc = 1;
            for (int k = 0; k < 8; k++) begin
                v[k] = c[k*8+i];
                if (k != 0 && v[k] != 0) dc = 0;
            end
            if (dc) begin
                d = wrap(v[0] << p1, w32);
                for (int k = 0; k < 8; k++) ws[k*8+i] = d;
            end else begin
                idct_1d(v, r);
                for (int k = 0; k < 8; k++)
                    ws[k*8+i] = round_shift(wrap(r[k], w32), 13 - p1, w32);
            end
        end
        for (int i = 0; i < 8; i++) begin
            dc = 1;
            for (int k = 0; k < 8; k++) begin
                v[k] = ws[i*8+k];
                if (k != 0 && v[k] != 0) dc = 0;
            end
            if (!dc) idct_1d(v, r);
            for (int k = 0; k < 8; k++) begin
                if (dc) d = level_clamp(round_shift(v[0], p1 + 3, w32), lvl, mx, w32);
                else d = level_clamp(round_shift(wrap(r[k], w32), 16 + p1, w32),
                                     lvl, mx, w32);
                s.sample = d[SAMPLE_W-1:0];
                s.last   = (i == 7 && k == 7);
                expected_samples.push_back(s);
            end
        end
        blocks_done++;
    endfunction

    // accepted coefficients feed the predictor
    always @(posedge i_clk) begin
        if (i_rst_n && coef.valid && coef.ready) begin
            coef_taken = 1;
            coef_store[load_idx] = coef.coefficient;
            load_idx++;
            if (load_idx == 64) begin
                load_idx = 0;
                predict_block();
            end
        end
    end

    // coefficient driver
    always @(negedge i_clk) begin : coef_drive
        logic                 nv;
        logic signed [CB-1:0] nc;
        nv = coef.valid;
        nc = coef.coefficient;
        if (!i_rst_n) nv = 0;
        else if (!coef.valid || coef_taken) begin
            nv = 0;
            if (coef_pending.size() > 0 && $urandom_range(99) >= send_idle) begin
                nv = 1;
                nc = coef_pending.pop_front();
            end
        end
        coef_taken = 0;
        coef.valid       <= nv;
        coef.coefficient <= nc;
    end

    // sample receiver, with an optional long hold-off
    always @(negedge i_clk) begin
        if (hold_cycles > 0) begin
            hold_cycles = hold_cycles - 1;
            samp.ready <= 1'b0;
        end else begin
            samp.ready <= i_rst_n && ($urandom_range(99) >= recv_idle);
        end
    end

    // sample checker
    always @(posedge i_clk) begin : samp_check
        t_samp want;
        if (i_rst_n && samp.valid && samp.ready) begin
            if (expected_samples.size() == 0) begin
                report_mismatch("unexpected sample", out_idx, samp.sample, -1);
            end else begin
                want = expected_samples.pop_front();
                if (samp.sample !== want.sample)
                    report_mismatch("sample", out_idx, samp.sample, want.sample);
                if (samp.last_of_block !== want.last)
                    report_mismatch("last_of_block", out_idx, samp.last_of_block, want.last);
            end
            out_idx++;
            samples_checked++;
        end
    end

    // ---------------- stimulus ----------------
    function automatic logic signed [CB-1:0] rand_coef(input t_blk_kind kind, input int idx);
        case (kind)
            BLK_SPARSE: begin
                if ($urandom_range(3) != 0) return '0;
                return CB'($signed($urandom_range(511)) - 256);
            end
            BLK_FULL:   return CB'($urandom);
            BLK_DC_ROW: begin
                if (idx >= 8) return '0;
                return CB'($signed($urandom_range(8191)) - 4096);
            end
            default:    return CB'($signed($urandom_range(65535)) - 32768);
        endcase
    endfunction

    task automatic push_random_block();
        t_blk_kind kind;
        kind = t_blk_kind'($urandom_range(3));
        for (int i = 0; i < 64; i++) coef_pending.push_back(rand_coef(kind, i));
    endtask

    task automatic push_fill_block(input logic signed [CB-1:0] a, input logic signed [CB-1:0] b,
                                   input bit dc_only);
        for (int i = 0; i < 64; i++)
            coef_pending.push_back(dc_only ? ((i == 0) ? a : '0) : ((i % 2) ? b : a));
    endtask

    // directed corners: DC-only extreme, alternating full-scale
    task automatic push_directed();
        push_fill_block(CB'(1048575), '0, 1);
        push_fill_block(CB'(1048575), CB'(-1048576), 0);
    endtask

    task automatic write_mode(input bit m);
        @(negedge i_clk);
        cfg.valid           <= 1'b1;
        cfg.twelve_bit_mode <= m;
        do @(posedge i_clk); while (!cfg.ready);
        mode12 = m;
        @(negedge i_clk);
        cfg.valid <= 1'b0;
    endtask

    task automatic drain();
        wait (coef_pending.size() == 0 && !coef.valid);
        wait (expected_samples.size() == 0);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    initial begin
        i_rst_n = 1'b0;
        coef.valid = 1'b0;
        coef.coefficient = '0;
        samp.ready = 1'b0;
        cfg.valid = 1'b0;
        cfg.twelve_bit_mode = 1'b0;
        load_idx = 0; mode12 = 0; coef_taken = 0;
        errors = 0; cycles = 0; blocks_done = 0; samples_checked = 0; out_idx = 0;
        hold_cycles = 0;
        send_idle = 25; recv_idle = 59;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        repeat (SETTLE) @(posedge i_clk);

        // 8-bit mode, sender idles lightly, receiver heavily
        write_mode(0);
        push_directed();
        push_random_block();
        drain();

        // 12-bit mode, idling swapped
        send_idle = 59; recv_idle = 25;
        write_mode(1);
        push_directed();
        push_random_block();
        drain();

        // 8-bit mode, no idling, long output stall to back up the input
        send_idle = 0; recv_idle = 0;
        write_mode(0);
        hold_cycles = 800;
        repeat (2) push_random_block();
        drain();

        $display("covered %0d blocks, %0d samples, both precision modes, with stalls",
                 blocks_done, samples_checked);
        if (errors == 0) begin
            $display("tb_idct_8x8_islow: clean");
        end else begin
            $display("%0d mismatches", errors);
            $display("tb_idct_8x8_islow: errors");
        end
        $finish;
    end

endmodule
